// ===== rtl/csprot_pkg.sv =====
`default_nettype none
package csprot_pkg;

    localparam int PhaseSteps   = 32;
    localparam int Quarter      = PhaseSteps / 4;
    localparam int CoefFracBits = 14;
    localparam int MaxChannels  = 1024;
    localparam int MaxAntennas  = 64;

    localparam int KW    = $clog2(PhaseSteps);
    localparam int CHW   = $clog2(MaxChannels);
    localparam int ANTW  = $clog2(MaxAntennas);
    localparam int COEFW = CoefFracBits + 2;
    localparam int PRODW = COEFW + 9;
    localparam int SUMW  = PRODW + 1;

    localparam logic [1:0] REG_NUM_CHANNELS   = 2'd0;
    localparam logic [1:0] REG_NUM_ANTENNAS   = 2'd1;
    localparam logic [1:0] REG_CHANNEL_OFFSET = 2'd2;

    typedef struct packed {
        logic signed [7:0] sample_re;
        logic signed [7:0] sample_im;
        logic              block_start;
    } t_in;

    typedef struct packed {
        logic signed [7:0] out_re;
        logic signed [7:0] out_im;
        logic              clamped;
    } t_out;

    typedef struct packed {
        logic en_out;
    } t_pipe_ctl;

    typedef struct packed {
        logic              clip;
        logic signed [7:0] val;
    } t_fin;

    localparam logic signed [COEFW-1:0] QUARTER_SINE [Quarter+1] = '{
        16'sd0, 16'sd3196, 16'sd6270, 16'sd9102, 16'sd11585,
        16'sd13623, 16'sd15137, 16'sd16069, 16'sd16384
    };

    // sine over a full turn folded onto the quarter-wave table
    function automatic logic signed [COEFW-1:0] sine_at(input logic [KW-1:0] n);
        logic [KW:0] m;
        logic signed [COEFW-1:0] r;
        m = {1'b0, n};
        if (m <= (KW+1)'(Quarter))
            r = QUARTER_SINE[m[KW-2:0]];
        else if (m <= (KW+1)'(2 * Quarter))
            r = QUARTER_SINE[4'((KW+1)'(2 * Quarter) - m)];
        else if (m <= (KW+1)'(3 * Quarter))
            r = -QUARTER_SINE[4'(m - (KW+1)'(2 * Quarter))];
        else
            r = -QUARTER_SINE[4'((KW+1)'(4 * Quarter) - m)];
        return r;
    endfunction

    // remove the half offset, floor divide by 2^(frac+1), saturate to 8 bits
    function automatic t_fin finish(input logic signed [SUMW-1:0] sum);
        logic signed [SUMW:0] d;
        logic signed [SUMW-CoefFracBits-1:0] v;
        t_fin r;
        d = {sum[SUMW-1], sum} - (SUMW+1)'(1 << CoefFracBits);
        v = d[SUMW:CoefFracBits+1];
        if (v > 127) begin
            r.clip = 1'b1;
            r.val  = 8'sd127;
        end else if (v < -128) begin
            r.clip = 1'b1;
            r.val  = -8'sd128;
        end else begin
            r.clip = 1'b0;
            r.val  = v[7:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/complex_sample_phase_rotator.sv =====
// Throughput: one beat per cycle while i_stall does not hold the pipe. Two
// registered stages (phase index with sample capture, then products/sum/
// floor/saturate into the result register); o_valid follows the second.
// Reset (synchronous, active low) empties the pipe, clears the antenna,
// channel and frame counters and loads the register reset values.
`default_nettype none
module complex_sample_phase_rotator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire csprot_pkg::t_in    i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output csprot_pkg::t_out        o_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [10:0] r_nchan;
    logic [6:0]  r_nant;
    logic [15:0] r_offset;

    logic r_v1, r_v2;
    logic out_rdy, s1_rdy, acc;
    logic [csprot_pkg::KW-1:0] k_now, r_k1;
    logic signed [7:0] r_re1, r_im1;
    csprot_pkg::t_pipe_ctl ctl;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nchan  <= 11'd128;
            r_nant   <= 7'd1;
            r_offset <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                csprot_pkg::REG_NUM_CHANNELS:   r_nchan  <= pwdata[10:0];
                csprot_pkg::REG_NUM_ANTENNAS:   r_nant   <= pwdata[6:0];
                csprot_pkg::REG_CHANNEL_OFFSET: r_offset <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            csprot_pkg::REG_NUM_CHANNELS:   prdata = {21'd0, r_nchan};
            csprot_pkg::REG_NUM_ANTENNAS:   prdata = {25'd0, r_nant};
            csprot_pkg::REG_CHANNEL_OFFSET: prdata = {16'd0, r_offset};
            default:                        prdata = '0;
        endcase
    end

    // each stage moves on when the next one is empty or draining
    assign out_rdy = !r_v2 || !i_stall;
    assign s1_rdy  = !r_v1 || out_rdy;
    assign o_stall = !s1_rdy;
    assign acc     = i_valid && s1_rdy;

    assign ctl.en_out = r_v1 && out_rdy;

    csprot_phase u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (acc),
        .i_block_start (i_data.block_start),
        .i_nchan       (r_nchan),
        .i_nant        (r_nant),
        .i_offset      (r_offset),
        .o_k           (k_now)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_rdy)  r_v1 <= i_valid;
            if (out_rdy) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_k1  <= k_now;
            r_re1 <= i_data.sample_re;
            r_im1 <= i_data.sample_im;
        end
    end

    csprot_mix u_mix (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_k    (r_k1),
        .i_re   (r_re1),
        .i_im   (r_im1),
        .o_data (o_data)
    );

    assign o_valid = r_v2;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2))
        else $error("input stalled while the pipe has room");

    a_block_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_data.block_start) |=> (r_k1 == '0))
        else $error("block start beat did not get phase index zero");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.clamped) |->
            (o_data.out_re == 8'sd127 || o_data.out_re == -8'sd128 ||
             o_data.out_im == 8'sd127 || o_data.out_im == -8'sd128))
        else $error("clamp flag set without a saturated part");

    a_out_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && out_rdy) |=> o_valid)
        else $error("stage one beat lost on its way to the output");

endmodule
`default_nettype wire

// ===== rtl/csprot_phase.sv =====
`default_nettype none
module csprot_phase (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_block_start,
    input  wire logic [10:0]                 i_nchan,
    input  wire logic [6:0]                  i_nant,
    input  wire logic [15:0]                 i_offset,
    output logic [csprot_pkg::KW-1:0]        o_k
);

    logic [csprot_pkg::ANTW-1:0] r_ant, n_ant, ant_base;
    logic [csprot_pkg::CHW-1:0]  r_chan, n_chan, chan_base;
    logic [csprot_pkg::KW-1:0]   r_frame, n_frame, frame_base;
    logic [10:0] nchan_eff;
    logic [6:0]  nant_eff;
    logic [csprot_pkg::ANTW:0] ant_inc;
    logic [csprot_pkg::CHW:0]  chan_inc;
    logic [csprot_pkg::KW-1:0] chan_abs, chan_mul;

    always_comb begin
        if (i_nchan == '0)
            nchan_eff = 11'd1;
        else if (i_nchan > 11'(csprot_pkg::MaxChannels))
            nchan_eff = 11'(csprot_pkg::MaxChannels);
        else
            nchan_eff = i_nchan;

        if (i_nant == '0)
            nant_eff = 7'd1;
        else if (i_nant > 7'(csprot_pkg::MaxAntennas))
            nant_eff = 7'(csprot_pkg::MaxAntennas);
        else
            nant_eff = i_nant;
    end

    assign ant_base   = i_block_start ? '0 : r_ant;
    assign chan_base  = i_block_start ? '0 : r_chan;
    assign frame_base = i_block_start ? '0 : r_frame;

    // only the low bits of the channel index survive mod 32
    assign chan_abs = chan_base[csprot_pkg::KW-1:0] + i_offset[csprot_pkg::KW-1:0];
    assign chan_mul = csprot_pkg::KW'(chan_abs * csprot_pkg::KW'(5));
    assign o_k      = csprot_pkg::KW'(chan_mul * frame_base);

    assign ant_inc  = {1'b0, ant_base} + 1'b1;
    assign chan_inc = {1'b0, chan_base} + 1'b1;

    always_comb begin
        n_ant   = r_ant;
        n_chan  = r_chan;
        n_frame = r_frame;
        if (i_adv) begin
            n_chan  = chan_base;
            n_frame = frame_base;
            if (7'(ant_inc) >= nant_eff) begin
                n_ant = '0;
                if (11'(chan_inc) >= nchan_eff) begin
                    n_chan  = '0;
                    n_frame = frame_base + 1'b1;
                end else begin
                    n_chan = chan_inc[csprot_pkg::CHW-1:0];
                end
            end else begin
                n_ant = ant_inc[csprot_pkg::ANTW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ant   <= '0;
            r_chan  <= '0;
            r_frame <= '0;
        end else begin
            r_ant   <= n_ant;
            r_chan  <= n_chan;
            r_frame <= n_frame;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/csprot_mix.sv =====
`default_nettype none
module csprot_mix (
    input  wire logic                         i_clk,
    input  wire csprot_pkg::t_pipe_ctl        i_ctl,
    input  wire logic [csprot_pkg::KW-1:0]    i_k,
    input  wire logic signed [7:0]            i_re,
    input  wire logic signed [7:0]            i_im,
    output csprot_pkg::t_out                  o_data
);

    logic signed [csprot_pkg::COEFW-1:0] sin_v, cos_v;
    logic signed [8:0] a, b;
    logic signed [csprot_pkg::PRODW-1:0] p_as, p_bc, p_bs, p_ac;
    logic signed [csprot_pkg::SUMW-1:0] sum_re, sum_im;
    csprot_pkg::t_fin fin_re, fin_im;
    csprot_pkg::t_out r_out;

    assign sin_v = csprot_pkg::sine_at(i_k);
    assign cos_v = csprot_pkg::sine_at(i_k + csprot_pkg::KW'(csprot_pkg::Quarter));

    // doubled samples keep the half-LSB offset exact
    assign a = {i_re, 1'b1};
    assign b = {i_im, 1'b1};

    assign p_as = csprot_pkg::PRODW'(a * sin_v);
    assign p_bc = csprot_pkg::PRODW'(b * cos_v);
    assign p_bs = csprot_pkg::PRODW'(b * sin_v);
    assign p_ac = csprot_pkg::PRODW'(a * cos_v);

    assign sum_re = csprot_pkg::SUMW'(p_as) + csprot_pkg::SUMW'(p_bc);
    assign sum_im = csprot_pkg::SUMW'(p_bs) - csprot_pkg::SUMW'(p_ac);
    assign fin_re = csprot_pkg::finish(sum_re);
    assign fin_im = csprot_pkg::finish(sum_im);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_out.out_re  <= fin_re.val;
            r_out.out_im  <= fin_im.val;
            r_out.clamped <= fin_re.clip | fin_im.clip;
        end
    end

    assign o_data = r_out;

endmodule
`default_nettype wire

// ===== sim/tb_complex_sample_phase_rotator.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_complex_sample_phase_rotator;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_ITEMS  = 600;
    localparam int MAX_PRINTED   = 20;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int QSINE_Q14 [9] = '{0, 3196, 6270, 9102, 11585, 13623, 15137, 16069, 16384};

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    csprot_pkg::t_in i_data = '0;
    logic        i_stall = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        o_stall;
    logic        o_valid;
    csprot_pkg::t_out o_data;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of registers and position counters
    logic [10:0] cfg_nchan  = 11'd128;
    logic [6:0]  cfg_nant   = 7'd1;
    logic [15:0] cfg_offset = 16'd0;
    int          ant_pos    = 0;
    int          chan_pos   = 0;
    int          frame_pos  = 0;

    csprot_pkg::t_out rotated_q[$];

    int errors      = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    int results_ok  = 0;
    int clamp_seen  = 0;
    int reg_writes  = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_tick  = 0;

    complex_sample_phase_rotator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint sine_q14(int n);
        int m;
        m = n % 32;
        if (m <= 8) return longint'(QSINE_Q14[m]);
        if (m <= 16) return longint'(QSINE_Q14[16 - m]);
        if (m <= 24) return -longint'(QSINE_Q14[m - 16]);
        return -longint'(QSINE_Q14[32 - m]);
    endfunction

    // drop the half offset, floor by 2^15, clamp; returns {clip, value}
    function automatic logic [8:0] floor_sat(longint sum);
        longint v;
        v = (sum - 64'sd16384) >>> 15;
        if (v > 127) return {1'b1, 8'h7f};
        if (v < -128) return {1'b1, 8'h80};
        return {1'b0, v[7:0]};
    endfunction

    function automatic csprot_pkg::t_out rotate_and_advance(csprot_pkg::t_in d);
        int nc;
        int na;
        int k;
        longint s;
        longint c;
        longint a;
        longint b;
        logic [8:0] re_f;
        logic [8:0] im_f;
        csprot_pkg::t_out r;
        nc = (cfg_nchan == 0) ? 1 : ((cfg_nchan > 1024) ? 1024 : int'(cfg_nchan));
        na = (cfg_nant == 0) ? 1 : ((cfg_nant > 64) ? 64 : int'(cfg_nant));
        if (d.block_start) begin
            ant_pos   = 0;
            chan_pos  = 0;
            frame_pos = 0;
        end
        k = int'(((longint'(chan_pos) + longint'(cfg_offset)) * 5 * frame_pos) % 32);
        s = sine_q14(k);
        c = sine_q14(k + 8);
        a = 2 * longint'(d.sample_re) + 1;
        b = 2 * longint'(d.sample_im) + 1;
        re_f = floor_sat(a * s + b * c);
        im_f = floor_sat(b * s - a * c);
        r.out_re  = re_f[7:0];
        r.out_im  = im_f[7:0];
        r.clamped = re_f[8] | im_f[8];
        ant_pos++;
        if (ant_pos >= na) begin
            ant_pos = 0;
            chan_pos++;
            if (chan_pos >= nc) begin
                chan_pos  = 0;
                frame_pos = (frame_pos + 1) % 32;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int expv, int gotv);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("tb: mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, expv, gotv);
    endtask

    // receiver stall pattern, switching style every so often
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 150 == 149)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            2: i_stall <= stall_tick[2];
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        csprot_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rotated_q.size() == 0) begin
                report_mismatch("unexpected beat, out_re", 0, o_data.out_re);
            end else begin
                want = rotated_q.pop_front();
                if (o_data.out_re !== want.out_re)
                    report_mismatch("out_re", want.out_re, o_data.out_re);
                if (o_data.out_im !== want.out_im)
                    report_mismatch("out_im", want.out_im, o_data.out_im);
                if (o_data.clamped !== want.clamped)
                    report_mismatch("clamped", want.clamped, o_data.clamped);
                results_ok++;
                if (want.clamped) clamp_seen++;
            end
        end
    end

    task automatic send_beat(csprot_pkg::t_in d);
        i_valid <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rotated_q.push_back(rotate_and_advance(d));
        items_sent++;
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            csprot_pkg::REG_NUM_CHANNELS:   cfg_nchan  = val[10:0];
            csprot_pkg::REG_NUM_ANTENNAS:   cfg_nant   = val[6:0];
            csprot_pkg::REG_CHANNEL_OFFSET: cfg_offset = val[15:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic logic [7:0] extreme_value(int i);
        case (i % 6)
            0: return 8'h80;
            1: return 8'h7f;
            2: return 8'h00;
            3: return 8'hff;
            4: return 8'h01;
            default: return 8'h81;
        endcase
    endfunction

    task automatic send_extremes(int count, bit first_starts_block);
        csprot_pkg::t_in d;
        for (int i = 0; i < count; i++) begin
            d.sample_re   = extreme_value(i);
            d.sample_im   = extreme_value(i * 5 + 1);
            d.block_start = first_starts_block && (i == 0);
            send_beat(d);
        end
    endtask

    // reset register values, field extremes at frame zero
    task automatic test_reset_values();
        send_extremes(4, 1'b1);
        drain_pipe();
    endtask

    // one channel, one antenna: every sample steps the frame, so the phase moves
    task automatic test_phase_sweep();
        write_reg(csprot_pkg::REG_NUM_CHANNELS, 32'd1);
        write_reg(csprot_pkg::REG_NUM_ANTENNAS, 32'd1);
        write_reg(csprot_pkg::REG_CHANNEL_OFFSET, 32'd65535);
        send_extremes(8, 1'b1);
        drain_pipe();
    endtask

    // zero and oversized counts, junk upper bits, the spare address
    task automatic test_count_limits();
        write_reg(csprot_pkg::REG_NUM_CHANNELS, 32'hffff_f800);
        write_reg(csprot_pkg::REG_NUM_ANTENNAS, 32'd0);
        send_extremes(2, 1'b0);
        drain_pipe();
        write_reg(csprot_pkg::REG_NUM_CHANNELS, 32'd2047);
        write_reg(csprot_pkg::REG_NUM_ANTENNAS, 32'd127);
        send_extremes(2, 1'b0);
        drain_pipe();
        write_reg(REG_SPARE, 32'hffff_ffff);
        send_extremes(2, 1'b0);
        drain_pipe();
    endtask

    // antenna counter left above a lowered limit must wrap on its next step
    task automatic test_lowered_limit();
        write_reg(csprot_pkg::REG_NUM_CHANNELS, 32'd3);
        write_reg(csprot_pkg::REG_NUM_ANTENNAS, 32'd64);
        write_reg(csprot_pkg::REG_CHANNEL_OFFSET, 32'd7);
        send_extremes(5, 1'b0);
        drain_pipe();
        write_reg(csprot_pkg::REG_NUM_ANTENNAS, 32'd2);
        send_extremes(3, 1'b0);
        drain_pipe();
    endtask

    task automatic stream_samples(int count, int noise_pct);
        csprot_pkg::t_in d;
        int frame_len;
        int block_len;
        int pos;
        int gap;
        frame_len = ((cfg_nchan == 0) ? 1 : ((cfg_nchan > 1024) ? 1024 : int'(cfg_nchan)))
                  * ((cfg_nant == 0) ? 1 : ((cfg_nant > 64) ? 64 : int'(cfg_nant)));
        block_len = frame_len * $urandom_range(1, 6);
        pos = 0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
                else if ($urandom_range(0, 9) < 4) gap = 0;
                else gap = $urandom_range(1, 6);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            d.sample_re   = 8'($urandom_range(0, 255));
            d.sample_im   = 8'($urandom_range(0, 255));
            d.block_start = (pos == 0);
            // broken structure: stray or missing block starts
            if ($urandom_range(0, 99) < noise_pct) d.block_start = ~d.block_start;
            send_beat(d);
            pos++;
            if (pos >= block_len) begin
                pos = 0;
                block_len = frame_len * $urandom_range(1, 6);
            end
        end
    endtask

    task automatic test_random_streams();
        int target;
        int sel;
        logic [31:0] nch;
        logic [31:0] nan;
        logic [31:0] off;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            sel = $urandom_range(0, 11);
            case (sel)
                0: begin nch = 1024; nan = 1; end
                1: begin nch = 1; nan = 64; end
                2: begin nch = 0; nan = 0; end
                3: begin nch = 2047; nan = 127; end
                default: begin
                    nch = $urandom_range(1, 6);
                    nan = $urandom_range(1, 4);
                end
            endcase
            sel = $urandom_range(0, 9);
            off = (sel == 0) ? 32'd0 : ((sel == 1) ? 32'd65535 : $urandom_range(0, 65535));
            // upper bits beyond each register's width are don't-care
            if ($urandom_range(0, 3) == 0) begin
                nch = nch | ($urandom() & 32'hffff_f800);
                nan = nan | ($urandom() & 32'hffff_ff80);
                off = off | ($urandom() & 32'hffff_0000);
            end
            write_reg(csprot_pkg::REG_NUM_CHANNELS, nch);
            write_reg(csprot_pkg::REG_NUM_ANTENNAS, nan);
            write_reg(csprot_pkg::REG_CHANNEL_OFFSET, off);
            stream_samples($urandom_range(40, 90), 5);
            drain_pipe();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_phase_sweep();
        test_count_limits();
        test_lowered_limit();
        test_random_streams();
        drain_pipe();
        repeat (10) @(posedge i_clk);
        $display("tb: %0d samples rotated, %0d register writes, %0d results compared",
                 items_sent, reg_writes, results_ok);
        $display("tb: %0d saturated results, %0d mismatches", clamp_seen, errors);
        if (errors == 0 && rotated_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
